>>> src/bitmap_grid_with_set_bit_scan_assert.svh
// Assertion macros for the bit grid block and its port checker.
`ifndef BITMAP_GRID_WITH_SET_BIT_SCAN_ASSERT_SVH
`define BITMAP_GRID_WITH_SET_BIT_SCAN_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BGS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bgs_pkg.sv
// Package: shared types and constants of the bit grid block.
`default_nettype none
package bgs_pkg;

    localparam int OP_W      = 3;
    localparam int COORD_W   = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b1;

    localparam logic [CFG_W-1:0] COLS_RESET = 9'd256;
    localparam logic [CFG_W-1:0] ROWS_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 3'd0,
        OP_GET   = 3'd1,
        OP_START = 3'd2,
        OP_NEXT  = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    // which of the up to three bits of a set request is being written
    typedef enum logic [1:0] {
        TGT_MAIN = 2'd0,
        TGT_UP   = 2'd1,
        TGT_LEFT = 2'd2
    } t_tgt;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SET_RD,
        S_SET_WR,
        S_GET_RD,
        S_GET_WAIT,
        S_FETCH,
        S_FETCH_WAIT,
        S_NEXT,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> src/bgs_locate.sv
// Coordinate to word address and bit offset, with the in-use check.
`default_nettype none
module bgs_locate #(
    parameter int WORD_BITS = 32,
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    localparam int WPR   = (MAX_COLS + WORD_BITS - 1) / WORD_BITS,
    localparam int DEPTH = MAX_ROWS * WPR,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int WIW   = (WPR > 1) ? $clog2(WPR) : 1,
    localparam int BW    = $clog2(WORD_BITS),
    localparam int CW0   = $clog2(MAX_COLS + 1),
    localparam int RW0   = $clog2(MAX_ROWS + 1),
    localparam int ECW   = (CW0 > bgs_pkg::CFG_W) ? CW0 : bgs_pkg::CFG_W,
    localparam int ERW   = (RW0 > bgs_pkg::CFG_W) ? RW0 : bgs_pkg::CFG_W
) (
    input  wire logic [bgs_pkg::COORD_W-1:0] i_col,
    input  wire logic [bgs_pkg::COORD_W-1:0] i_row,
    input  wire logic [ECW-1:0]              i_eff_cols,
    input  wire logic [ERW-1:0]              i_eff_rows,
    output logic      [AW-1:0]               o_addr,
    output logic      [BW-1:0]               o_bit,
    output logic                             o_in_use
);

    logic [WIW-1:0] word_idx;

    // word index by threshold compare: no divider for odd word sizes
    always_comb begin
        word_idx = '0;
        for (int k = 1; k < WPR; k++) begin
            if (int'(i_col) >= k * WORD_BITS) begin
                word_idx = WIW'(k);
            end
        end
    end

    assign o_bit    = BW'(int'(i_col) - int'(word_idx) * WORD_BITS);
    assign o_addr   = AW'(int'(i_row) * WPR + int'(word_idx));
    assign o_in_use = (ECW'(i_col) < i_eff_cols) && (ERW'(i_row) < i_eff_rows);

endmodule
`default_nettype wire

>>> src/bitmap_grid_with_set_bit_scan.sv
// Top level: bit grid in one single-port memory with set, get, clear and scan.
//
//  channel   direction  handshake              payload
//  request   in         i_valid / o_ready      i_op i_col i_row i_left_border i_upper_border
//  result    out        o_valid / i_ready      o_bit_value o_found o_found_col o_found_row
//  config    in         i_cfg_we (no stall)    i_cfg_index i_cfg_data
//
// One request at a time; the grid memory does one access per cycle. get reads its word
// if in use; set reads and writes back each of its up to three bits if enabled and in use;
// start fetches the first word; next fetches words until a set bit turns up or the scan
// ends; clear all writes every word. After reset a clearing pass over all MAX_ROWS *
// ceil(MAX_COLS / WORD_BITS) words (2048 at defaults) holds o_ready low; config writes
// are taken throughout. A new request is taken while the previous result waits on i_ready.
`default_nettype none
module bitmap_grid_with_set_bit_scan #(
    parameter int WORD_BITS = 32,
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bgs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bgs_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [bgs_pkg::OP_W-1:0]          i_op,
    input  wire logic [bgs_pkg::COORD_W-1:0]       i_col,
    input  wire logic [bgs_pkg::COORD_W-1:0]       i_row,
    input  wire logic                              i_left_border,
    input  wire logic                              i_upper_border,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_bit_value,
    output logic                                   o_found,
    output logic      [bgs_pkg::COORD_W-1:0]       o_found_col,
    output logic      [bgs_pkg::COORD_W-1:0]       o_found_row
);

    localparam int WPR   = (MAX_COLS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH = MAX_ROWS * WPR;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIW   = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int CW0   = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int ECW   = (CW0 > bgs_pkg::CFG_W) ? CW0 : bgs_pkg::CFG_W;
    localparam int ERW   = (RW > bgs_pkg::CFG_W) ? RW : bgs_pkg::CFG_W;
    localparam int SBW   = $clog2(WPR * WORD_BITS + 1);
    localparam int MW    = (SBW > ECW) ? SBW : ECW;
    localparam int CW    = bgs_pkg::COORD_W;

    // control
    bgs_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic [bgs_pkg::CFG_W-1:0] r_cols, n_cols, r_rows, n_rows;
    logic [RW-1:0]   r_scan_row, n_scan_row;
    logic [WIW-1:0]  r_scan_widx, n_scan_widx;
    logic [WORD_BITS-1:0] r_scan_word, n_scan_word;
    logic            r_out_valid, n_out_valid;

    // payload
    bgs_pkg::t_op    r_op, n_op;
    bgs_pkg::t_tgt   r_tgt, n_tgt;
    logic [CW-1:0]   r_col, n_col, r_row, n_row;
    logic            r_left, n_left, r_up, n_up;
    logic            r_fetch_ok, n_fetch_ok;
    logic            r_res_bit, n_res_bit, r_res_found, n_res_found;
    logic [CW-1:0]   r_res_col, n_res_col, r_res_row, n_res_row;
    logic            r_out_bit, n_out_bit, r_out_found, n_out_found;
    logic [CW-1:0]   r_out_col, n_out_col, r_out_row, n_out_row;

    // grid memory
    logic [WORD_BITS-1:0] r_grid [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_re, mem_we;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;

    // derived
    logic [ECW-1:0]       eff_cols;
    logic [ERW-1:0]       eff_rows;
    logic [CW-1:0]        tgt_col, tgt_row;
    logic                 tgt_en, tgt_last;
    bgs_pkg::t_tgt        tgt_next;
    logic [AW-1:0]        loc_addr;
    logic [BW-1:0]        loc_bit;
    logic                 loc_in_use;
    logic [SBW-1:0]       base_cur, base_nxt;
    logic [WIW:0]         widx_inc;
    logic [RW-1:0]        row_inc;
    logic                 scan_over, fetch_ok;
    logic [AW-1:0]        fetch_addr;
    logic [WORD_BITS-1:0] fetch_mask;
    logic [BW-1:0]        lo_idx;

    assign eff_cols = (ECW'(r_cols) > ECW'(MAX_COLS)) ? ECW'(MAX_COLS) : ECW'(r_cols);
    assign eff_rows = (ERW'(r_rows) > ERW'(MAX_ROWS)) ? ERW'(MAX_ROWS) : ERW'(r_rows);

    // current bit of a set (or the get bit)
    assign tgt_col = (r_tgt == bgs_pkg::TGT_LEFT) ? r_col - CW'(1) : r_col;
    assign tgt_row = (r_tgt == bgs_pkg::TGT_UP) ? r_row - CW'(1) : r_row;
    assign tgt_en  = (r_tgt == bgs_pkg::TGT_MAIN)
                  || ((r_tgt == bgs_pkg::TGT_UP) && r_up && (r_row != '0))
                  || ((r_tgt == bgs_pkg::TGT_LEFT) && r_left && (r_col != '0));
    assign tgt_last = (r_tgt == bgs_pkg::TGT_LEFT);

    always_comb begin
        case (r_tgt)
            bgs_pkg::TGT_MAIN: tgt_next = bgs_pkg::TGT_UP;
            default:           tgt_next = bgs_pkg::TGT_LEFT;
        endcase
    end

    bgs_locate #(
        .WORD_BITS (WORD_BITS),
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS)
    ) u_locate (
        .i_col      (tgt_col),
        .i_row      (tgt_row),
        .i_eff_cols (eff_cols),
        .i_eff_rows (eff_rows),
        .o_addr     (loc_addr),
        .o_bit      (loc_bit),
        .o_in_use   (loc_in_use)
    );

    // scan position arithmetic
    assign base_cur   = SBW'(int'(r_scan_widx) * WORD_BITS);
    assign widx_inc   = {1'b0, r_scan_widx} + (WIW+1)'(1);
    assign base_nxt   = SBW'(int'(widx_inc) * WORD_BITS);
    assign row_inc    = r_scan_row + RW'(1);
    assign scan_over  = ERW'(r_scan_row) >= eff_rows;
    assign fetch_ok   = (ERW'(r_scan_row) < eff_rows) && (MW'(base_cur) < MW'(eff_cols));
    assign fetch_addr = AW'(int'(r_scan_row) * WPR + int'(r_scan_widx));

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            fetch_mask[j] = (MW'(base_cur) + MW'(j)) < MW'(eff_cols);
        end
    end

    always_comb begin
        lo_idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (r_scan_word[j]) begin
                lo_idx = BW'(j);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_scan_row  = r_scan_row;
        n_scan_widx = r_scan_widx;
        n_scan_word = r_scan_word;
        n_out_valid = r_out_valid && !i_ready;
        n_op        = r_op;
        n_tgt       = r_tgt;
        n_col       = r_col;
        n_row       = r_row;
        n_left      = r_left;
        n_up        = r_up;
        n_fetch_ok  = r_fetch_ok;
        n_res_bit   = r_res_bit;
        n_res_found = r_res_found;
        n_res_col   = r_res_col;
        n_res_row   = r_res_row;
        n_out_bit   = r_out_bit;
        n_out_found = r_out_found;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = loc_addr;
        mem_wdata   = r_rdata | (WORD_BITS'(1) << loc_bit);
        o_ready     = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                bgs_pkg::CFG_COLS_IN_USE: n_cols = i_cfg_data;
                bgs_pkg::CFG_ROWS_IN_USE: n_rows = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            bgs_pkg::S_INIT, bgs_pkg::S_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = (r_state == bgs_pkg::S_INIT) ? bgs_pkg::S_IDLE
                                                           : bgs_pkg::S_DONE;
                end
            end
            bgs_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op        = bgs_pkg::t_op'(i_op);
                    n_col       = i_col;
                    n_row       = i_row;
                    n_left      = i_left_border;
                    n_up        = i_upper_border;
                    n_tgt       = bgs_pkg::TGT_MAIN;
                    n_clr_addr  = '0;
                    n_res_bit   = 1'b0;
                    n_res_found = 1'b0;
                    n_res_col   = '0;
                    n_res_row   = '0;
                    case (bgs_pkg::t_op'(i_op))
                        bgs_pkg::OP_SET:   n_state = bgs_pkg::S_SET_RD;
                        bgs_pkg::OP_GET:   n_state = bgs_pkg::S_GET_RD;
                        bgs_pkg::OP_START: begin
                            n_scan_row  = '0;
                            n_scan_widx = '0;
                            n_state     = bgs_pkg::S_FETCH;
                        end
                        bgs_pkg::OP_NEXT:  n_state = bgs_pkg::S_NEXT;
                        bgs_pkg::OP_CLEAR: n_state = bgs_pkg::S_CLEAR;
                        default:           n_state = bgs_pkg::S_DONE;
                    endcase
                end
            end
            bgs_pkg::S_SET_RD: begin
                if (tgt_en && loc_in_use) begin
                    mem_re  = 1'b1;
                    n_state = bgs_pkg::S_SET_WR;
                end else if (tgt_last) begin
                    n_state = bgs_pkg::S_DONE;
                end else begin
                    n_tgt = tgt_next;
                end
            end
            bgs_pkg::S_SET_WR: begin
                // the next read comes in the cycle after this write, so a shared word sees it
                mem_we = 1'b1;
                if (tgt_last) begin
                    n_state = bgs_pkg::S_DONE;
                end else begin
                    n_tgt   = tgt_next;
                    n_state = bgs_pkg::S_SET_RD;
                end
            end
            bgs_pkg::S_GET_RD: begin
                if (loc_in_use) begin
                    mem_re  = 1'b1;
                    n_state = bgs_pkg::S_GET_WAIT;
                end else begin
                    n_state = bgs_pkg::S_DONE;
                end
            end
            bgs_pkg::S_GET_WAIT: begin
                n_res_bit = r_rdata[loc_bit];
                n_state   = bgs_pkg::S_DONE;
            end
            bgs_pkg::S_FETCH: begin
                mem_re     = fetch_ok;
                mem_addr   = fetch_addr;
                n_fetch_ok = fetch_ok;
                n_state    = bgs_pkg::S_FETCH_WAIT;
            end
            bgs_pkg::S_FETCH_WAIT: begin
                n_scan_word = r_fetch_ok ? (r_rdata & fetch_mask) : '0;
                n_state     = (r_op == bgs_pkg::OP_START) ? bgs_pkg::S_DONE
                                                          : bgs_pkg::S_NEXT;
            end
            bgs_pkg::S_NEXT: begin
                if (scan_over) begin
                    n_state = bgs_pkg::S_DONE;
                end else if (r_scan_word != '0) begin
                    // hand out the lowest set bit of the snapshot
                    n_scan_word = r_scan_word & (r_scan_word - WORD_BITS'(1));
                    n_res_found = 1'b1;
                    n_res_col   = CW'(int'(base_cur) + int'(lo_idx));
                    n_res_row   = CW'(r_scan_row);
                    n_state     = bgs_pkg::S_DONE;
                end else if (MW'(base_nxt) >= MW'(eff_cols)) begin
                    n_scan_widx = '0;
                    if (ERW'(row_inc) >= eff_rows) begin
                        n_scan_row = RW'(MAX_ROWS);
                        n_state    = bgs_pkg::S_DONE;
                    end else begin
                        n_scan_row = row_inc;
                        n_state    = bgs_pkg::S_FETCH;
                    end
                end else begin
                    n_scan_widx = WIW'(widx_inc);
                    n_state     = bgs_pkg::S_FETCH;
                end
            end
            bgs_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res_bit;
                    n_out_found = r_res_found;
                    n_out_col   = r_res_col;
                    n_out_row   = r_res_row;
                    n_state     = bgs_pkg::S_IDLE;
                end
            end
            default: n_state = bgs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bgs_pkg::S_INIT;
            r_clr_addr  <= '0;
            r_cols      <= bgs_pkg::COLS_RESET;
            r_rows      <= bgs_pkg::ROWS_RESET;
            r_scan_row  <= RW'(MAX_ROWS);
            r_scan_widx <= '0;
            r_scan_word <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cols      <= n_cols;
            r_rows      <= n_rows;
            r_scan_row  <= n_scan_row;
            r_scan_widx <= n_scan_widx;
            r_scan_word <= n_scan_word;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_tgt       <= n_tgt;
        r_col       <= n_col;
        r_row       <= n_row;
        r_left      <= n_left;
        r_up        <= n_up;
        r_fetch_ok  <= n_fetch_ok;
        r_res_bit   <= n_res_bit;
        r_res_found <= n_res_found;
        r_res_col   <= n_res_col;
        r_res_row   <= n_res_row;
        r_out_bit   <= n_out_bit;
        r_out_found <= n_out_found;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_grid[mem_addr];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_bit_value = r_out_bit;
    assign o_found     = r_out_found;
    assign o_found_col = r_out_col;
    assign o_found_row = r_out_row;

endmodule
`default_nettype wire

>>> src/bgs_checker.sv
// Port checker for the bit grid block, bound to the top level.
`default_nettype none
`include "bitmap_grid_with_set_bit_scan_assert.svh"
module bgs_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic                        o_bit_value,
    input wire logic                        o_found,
    input wire logic [bgs_pkg::COORD_W-1:0] o_found_col,
    input wire logic [bgs_pkg::COORD_W-1:0] o_found_row
);

    `BGS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped before taken")

    `BGS_ASSERT_NEXT(a_out_stable, o_valid && !i_ready, $stable(o_bit_value) && $stable(o_found) && $stable(o_found_col) && $stable(o_found_row), "result changed while stalled")

    // a miss reports a zero position
    `BGS_ASSERT_NOW(a_miss_zero, o_valid && !o_found, (o_found_col == '0) && (o_found_row == '0), "position nonzero without found")

    // get and next results never both carry a one
    `BGS_ASSERT_NOW(a_one_kind, o_valid, !(o_found && o_bit_value), "found and bit_value both set")

endmodule

bind bitmap_grid_with_set_bit_scan bgs_checker u_bgs_checker (.*);
`default_nettype wire

>>> tb/bitmap_grid_with_set_bit_scan_tb.sv
// Self-checking testbench for the bit grid block: directed, pressure and random traffic.
`timescale 1ns / 1ps
module bitmap_grid_with_set_bit_scan_tb;

    localparam int OP_W           = bgs_pkg::OP_W;
    localparam int COORD_W        = bgs_pkg::COORD_W;
    localparam int CFG_W          = bgs_pkg::CFG_W;
    localparam int CFG_IDX_W      = bgs_pkg::CFG_IDX_W;
    localparam int WORD_BITS      = 32;
    localparam int MAX_COLS       = 256;
    localparam int MAX_ROWS       = 256;
    localparam int ROW_WORDS      = (MAX_COLS + WORD_BITS - 1) / WORD_BITS;
    localparam int GRID_WORDS     = MAX_ROWS * ROW_WORDS;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_ITEMS   = 460;
    localparam int ITEMS_PER_CFG  = 120;

    // op codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               left;
        logic               up;
    } t_grid_req;

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [COORD_W-1:0] found_col;
        logic [COORD_W-1:0] found_row;
    } t_grid_resp;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [OP_W-1:0]      i_op;
    logic [COORD_W-1:0]   i_col;
    logic [COORD_W-1:0]   i_row;
    logic                 i_left_border;
    logic                 i_upper_border;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_bit_value;
    logic                 o_found;
    logic [COORD_W-1:0]   o_found_col;
    logic [COORD_W-1:0]   o_found_row;

    bitmap_grid_with_set_bit_scan #(
        .WORD_BITS (WORD_BITS),
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_left_border  (i_left_border),
        .i_upper_border (i_upper_border),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bit_value    (o_bit_value),
        .o_found        (o_found),
        .o_found_col    (o_found_col),
        .o_found_row    (o_found_row)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the grid, the scan cursor and the two limit registers
    logic [WORD_BITS-1:0] grid_shadow [GRID_WORDS];
    int unsigned          cursor_row;
    int unsigned          cursor_col;
    logic [WORD_BITS-1:0] cursor_bits;
    logic [CFG_W-1:0]     col_limit_reg;
    logic [CFG_W-1:0]     row_limit_reg;

    t_grid_resp pending_responses [$];
    t_grid_resp want_resp;
    int         error_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         holdoff_req    = 1'b0;
    int         stall_cycles   = 0;

    function automatic int unsigned cols_active();
        return (32'(col_limit_reg) > MAX_COLS) ? MAX_COLS : 32'(col_limit_reg);
    endfunction

    function automatic int unsigned rows_active();
        return (32'(row_limit_reg) > MAX_ROWS) ? MAX_ROWS : 32'(row_limit_reg);
    endfunction

    function automatic bit cell_active(int unsigned c, int unsigned r);
        return c < cols_active() && r < rows_active();
    endfunction

    function automatic void mark_cell(int unsigned c, int unsigned r);
        if (cell_active(c, r))
            grid_shadow[r * ROW_WORDS + c / WORD_BITS][c % WORD_BITS] = 1'b1;
    endfunction

    // word holding column c, trimmed to the columns in use
    function automatic logic [WORD_BITS-1:0] snapshot_word(int unsigned c, int unsigned r);
        int unsigned          lim;
        int unsigned          base;
        logic [WORD_BITS-1:0] w;
        lim  = cols_active();
        base = (c / WORD_BITS) * WORD_BITS;
        if (r >= rows_active() || base >= lim)
            return '0;
        w = grid_shadow[r * ROW_WORDS + c / WORD_BITS];
        if (lim - base < WORD_BITS)
            w &= ~({WORD_BITS{1'b1}} << (lim - base));
        return w;
    endfunction

    function automatic t_grid_resp next_set_bit();
        t_grid_resp rsp;
        rsp = '0;
        if (cursor_row >= rows_active())
            return rsp;
        while (cursor_bits == '0) begin
            cursor_col = (cursor_col / WORD_BITS + 1) * WORD_BITS;
            if (cursor_col >= cols_active()) begin
                cursor_row++;
                if (cursor_row >= rows_active()) begin
                    cursor_row = MAX_ROWS;
                    cursor_col = 0;
                    return rsp;
                end
                cursor_col = 0;
            end
            cursor_bits = snapshot_word(cursor_col, cursor_row);
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            if (cursor_bits[j]) begin
                cursor_bits[j] = 1'b0;
                cursor_col     = (cursor_col / WORD_BITS) * WORD_BITS + j;
                rsp.found      = 1'b1;
                rsp.found_col  = cursor_col[COORD_W-1:0];
                rsp.found_row  = cursor_row[COORD_W-1:0];
                break;
            end
        end
        return rsp;
    endfunction

    function automatic t_grid_resp grid_response(t_grid_req q);
        t_grid_resp  rsp;
        int unsigned c;
        int unsigned r;
        rsp = '0;
        c   = 32'(q.col);
        r   = 32'(q.row);
        case (q.op)
            bgs_pkg::OP_SET: begin
                mark_cell(c, r);
                if (q.up && r >= 1)
                    mark_cell(c, r - 1);
                if (q.left && c >= 1)
                    mark_cell(c - 1, r);
            end
            bgs_pkg::OP_GET: begin
                if (cell_active(c, r))
                    rsp.bit_value =
                        grid_shadow[r * ROW_WORDS + c / WORD_BITS][c % WORD_BITS];
            end
            bgs_pkg::OP_START: begin
                cursor_row  = 0;
                cursor_col  = 0;
                cursor_bits = snapshot_word(0, 0);
            end
            bgs_pkg::OP_NEXT:  rsp = next_set_bit();
            bgs_pkg::OP_CLEAR: foreach (grid_shadow[i]) grid_shadow[i] = '0;
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void shadow_reset();
        foreach (grid_shadow[i]) grid_shadow[i] = '0;
        cursor_row    = MAX_ROWS;
        cursor_col    = 0;
        cursor_bits   = '0;
        col_limit_reg = bgs_pkg::COLS_RESET;
        row_limit_reg = bgs_pkg::ROWS_RESET;
    endfunction

    function automatic logic [COORD_W-1:0] rand_col();
        if (cols_active() == 0 || $urandom_range(0, 99) < 12)
            return COORD_W'($urandom_range(0, MAX_COLS - 1));
        return COORD_W'($urandom_range(0, cols_active() - 1));
    endfunction

    function automatic logic [COORD_W-1:0] rand_row();
        if (rows_active() == 0 || $urandom_range(0, 99) < 12)
            return COORD_W'($urandom_range(0, MAX_ROWS - 1));
        return COORD_W'($urandom_range(0, rows_active() - 1));
    endfunction

    // enters and leaves at a falling edge; valid stays up for the caller to reuse or drop
    task automatic send_req(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] row, input logic left, input logic up);
        t_grid_req q;
        q = '{op: op, col: col, row: row, left: left, up: up};
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= q.op;
        i_col          <= q.col;
        i_row          <= q.row;
        i_left_border  <= q.left;
        i_upper_border <= q.up;
        do @(posedge i_clk); while (!o_ready);
        pending_responses.push_back(grid_response(q));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_responses.size() != 0);
    endtask

    // only called with the block idle
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bgs_pkg::CFG_COLS_IN_USE)
            col_limit_reg = val;
        else
            row_limit_reg = val;
        @(negedge i_clk);
    endtask

    task automatic set_limits(input int unsigned cols, input int unsigned rows);
        wait_drained();
        write_limit(bgs_pkg::CFG_COLS_IN_USE, cols[CFG_W-1:0]);
        write_limit(bgs_pkg::CFG_ROWS_IN_USE, rows[CFG_W-1:0]);
    endtask

    task automatic send_nexts(input int n);
        repeat (n) send_req(bgs_pkg::OP_NEXT, COORD_W'($urandom_range(0, 255)),
                            COORD_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed_basics();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_req(bgs_pkg::OP_NEXT, 8'd0, 8'd0, 1'b0, 1'b0);       // no scan started yet
        send_req(OP_SPARE_5, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_req(OP_SPARE_6, 8'h00, 8'hFF, 1'b0, 1'b1);
        send_req(OP_SPARE_7, 8'hFF, 8'h00, 1'b1, 1'b0);
        send_req(bgs_pkg::OP_SET, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_req(bgs_pkg::OP_GET, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_GET, 8'hFE, 8'hFF, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_GET, 8'hFF, 8'hFE, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_GET, 8'hFE, 8'hFE, 1'b1, 1'b1);
        send_req(bgs_pkg::OP_SET, 8'd0, 8'd0, 1'b1, 1'b1);        // both borders fall off
        send_req(bgs_pkg::OP_SET, 8'd32, 8'd1, 1'b1, 1'b0);       // left border in prior word
        send_req(bgs_pkg::OP_GET, 8'd31, 8'd1, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_GET, 8'd32, 8'd1, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_GET, 8'd32, 8'd0, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_START, 8'd0, 8'd0, 1'b0, 1'b0);
        send_nexts(8);                                    // six bits, the end, then past the end
        send_req(bgs_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_GET, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_START, 8'd0, 8'd0, 1'b0, 1'b0);
        send_nexts(1);
    endtask

    task automatic test_register_extremes();
        set_limits(0, 0);                                 // nothing in use
        send_req(bgs_pkg::OP_SET, 8'd0, 8'd0, 1'b1, 1'b1);
        send_req(bgs_pkg::OP_GET, 8'd0, 8'd0, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_START, 8'd0, 8'd0, 1'b0, 1'b0);
        send_nexts(1);
        set_limits(511, 511);                             // saturates at the full grid
        send_req(bgs_pkg::OP_SET, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_req(bgs_pkg::OP_GET, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_GET, 8'd0, 8'd0, 1'b0, 1'b0);
        set_limits(1, 1);
        send_req(bgs_pkg::OP_SET, 8'd1, 8'd0, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_SET, 8'd0, 8'd1, 1'b1, 1'b1);        // only the upper border is in
        send_req(bgs_pkg::OP_GET, 8'd0, 8'd0, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_START, 8'd0, 8'd0, 1'b0, 1'b0);
        send_nexts(2);
        set_limits(256, 2);
        send_req(bgs_pkg::OP_SET, 8'd35, 8'd0, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_SET, 8'd32, 8'd0, 1'b1, 1'b0);
        set_limits(33, 2);                                // column 35 masked out of the snapshot
        send_req(bgs_pkg::OP_START, 8'd0, 8'd0, 1'b0, 1'b0);
        send_nexts(4);
        set_limits(256, 4);
        send_req(bgs_pkg::OP_SET, 8'd100, 8'd2, 1'b0, 1'b0);
        send_req(bgs_pkg::OP_SET, 8'd3, 8'd3, 1'b0, 1'b1);
        send_req(bgs_pkg::OP_START, 8'd0, 8'd0, 1'b0, 1'b0);
        send_nexts(1);
        // limits move under a running scan
        wait_drained();
        write_limit(bgs_pkg::CFG_ROWS_IN_USE, 9'd3);
        send_nexts(2);
        wait_drained();
        write_limit(bgs_pkg::CFG_COLS_IN_USE, 9'd50);
        send_nexts(4);
    endtask

    task automatic test_output_backpressure();
        set_limits(64, 8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 1'b1;
        send_req(bgs_pkg::OP_START, 8'd0, 8'd0, 1'b0, 1'b0);
        repeat (30) begin
            if ($urandom_range(0, 1))
                send_req(bgs_pkg::OP_SET, rand_col(), rand_row(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            else
                send_req(bgs_pkg::OP_GET, rand_col(), rand_row(), 1'b0, 1'b0);
        end
        send_nexts(10);
    endtask

    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        send_req(bgs_pkg::OP_START, 8'd0, 8'd0, 1'b0, 1'b0);
        send_nexts(5);
        wait_drained();
        send_nexts(5);                                    // scan picks up where it stopped
        wait_drained();
    endtask

    task automatic pick_random_limits();
        int unsigned pick;
        int unsigned cols;
        int unsigned rows;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            cols = $urandom_range(1, 100);
            rows = $urandom_range(1, 20);
        end else if (pick < 80) begin
            cols = 32 << $urandom_range(0, 3);
            rows = $urandom_range(1, 8);
        end else if (pick < 92) begin
            cols = $urandom_range(257, 511);
            rows = $urandom_range(1, 4);
        end else begin
            cols = $urandom_range(1, 40);
            rows = $urandom_range(257, 511);
        end
        set_limits(cols, rows);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int sent;
        int cfg_at;
        int pick;
        int burst;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent   = 0;
        cfg_at = 0;
        while (sent < n_items) begin
            if (sent >= cfg_at) begin
                pick_random_limits();
                cfg_at = sent + ITEMS_PER_CFG;
            end
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                send_req(bgs_pkg::OP_SET, rand_col(), rand_row(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                sent++;
            end else if (pick < 58) begin
                send_req(bgs_pkg::OP_GET, rand_col(), rand_row(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                sent++;
            end else if (pick < 65) begin
                burst = $urandom_range(1, 24);
                send_req(bgs_pkg::OP_START, rand_col(), rand_row(), 1'b0, 1'b0);
                send_nexts(burst);
                sent += burst + 1;
            end else if (pick < 84) begin
                send_nexts(1);
                sent++;
            end else if (pick < 98) begin
                // noise: any op, any coordinates
                send_req(OP_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 255)),
                         COORD_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                sent++;
            end else begin
                send_req(bgs_pkg::OP_CLEAR, rand_col(), rand_row(), 1'b0, 1'b0);
                sent++;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_responses.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want_resp = pending_responses.pop_front();
                if (o_bit_value !== want_resp.bit_value) begin
                    $error("bit_value: expected %0d, got %0d", want_resp.bit_value, o_bit_value);
                    error_count++;
                end
                if (o_found !== want_resp.found) begin
                    $error("found: expected %0d, got %0d", want_resp.found, o_found);
                    error_count++;
                end
                if (o_found_col !== want_resp.found_col) begin
                    $error("found_col: expected %0d, got %0d", want_resp.found_col, o_found_col);
                    error_count++;
                end
                if (o_found_row !== want_resp.found_row) begin
                    $error("found_row: expected %0d, got %0d", want_resp.found_row, o_found_row);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = bgs_pkg::CFG_COLS_IN_USE;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_op           = bgs_pkg::OP_SET;
        i_col          = '0;
        i_row          = '0;
        i_left_border  = 1'b0;
        i_upper_border = 1'b0;
        shadow_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_register_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(0, 0, RANDOM_ITEMS);
        test_random_traffic(47, 0, RANDOM_ITEMS);
        test_random_traffic(0, 47, RANDOM_ITEMS);
        test_random_traffic(16, 16, RANDOM_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/bgs_pkg.sv
src/bgs_locate.sv
src/bitmap_grid_with_set_bit_scan.sv
src/bgs_checker.sv
tb/bitmap_grid_with_set_bit_scan_tb.sv
